FILE: hdl/ccpt_pkg.sv
// Shared types, codes and letter table for the patch-code table.
package ccpt_pkg;

  localparam int unsigned ADDR_W   = 15;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LETTERS  = 8;
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned TOTAL_W    = 5;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CODE  = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  localparam logic [7:0] LEN_SHORT = 8'd6;
  localparam logic [7:0] LEN_LONG  = 8'd8;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] cmp;
    logic              cen;
  } entry_t;

  typedef struct packed {
    logic load_new;
    logic shift;
  } cell_ctl_t;

  // Letter to nibble; bit 4 set means the letter is not in the alphabet.
  function automatic logic [4:0] letter_value(input logic [7:0] c);
    logic [4:0] v;
    unique case (c)
      8'h41:   v = 5'h00; // A
      8'h50:   v = 5'h01; // P
      8'h5A:   v = 5'h02; // Z
      8'h4C:   v = 5'h03; // L
      8'h47:   v = 5'h04; // G
      8'h49:   v = 5'h05; // I
      8'h54:   v = 5'h06; // T
      8'h59:   v = 5'h07; // Y
      8'h45:   v = 5'h08; // E
      8'h4F:   v = 5'h09; // O
      8'h58:   v = 5'h0A; // X
      8'h55:   v = 5'h0B; // U
      8'h4B:   v = 5'h0C; // K
      8'h53:   v = 5'h0D; // S
      8'h56:   v = 5'h0E; // V
      8'h4E:   v = 5'h0F; // N
      default: v = 5'h10;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/ccpt_decode.sv
// Letter decode and bit scramble of one patch code into a table entry.
module ccpt_decode (
  input  logic [63:0]           code_chars,
  input  logic [7:0]            code_length,
  output ccpt_pkg::entry_t      entry,
  output logic                  bad_code
);
  import ccpt_pkg::*;

  logic [3:0] n [LETTERS];
  logic [4:0] lv [LETTERS];
  logic [LETTERS-1:0] bad_letter;
  logic is_short, is_long;

  always_comb begin
    for (int i = 0; i < LETTERS; i++) begin
      lv[i]         = letter_value(code_chars[8*i +: 8]);
      n[i]          = lv[i][3:0];
      bad_letter[i] = lv[i][4];
    end
  end

  assign is_short = (code_length == LEN_SHORT);
  assign is_long  = (code_length == LEN_LONG);

  // trailing two letters only count for long codes
  assign bad_code = !(is_short || is_long) || (|bad_letter[5:0]) ||
                    (is_long && (|bad_letter[7:6]));

  always_comb begin
    entry.addr = {n[3][2:0], n[4][3], n[5][2:0], n[1][3], n[2][2:0], n[3][3], n[4][2:0]};
    entry.data = {n[0][3], n[1][2:0], (is_long ? n[7][3] : n[5][3]), n[0][2:0]};
    entry.cmp  = is_long ? {n[6][3], n[7][2:0], n[5][3], n[6][2:0]} : '0;
    entry.cen  = is_long;
  end

endmodule

FILE: hdl/ccpt_cell.sv
// One table slot: holds an entry, loads a new one or takes its neighbor's, flags a match.
module ccpt_cell (
  input  logic                      clk,
  input  ccpt_pkg::cell_ctl_t       ctl,
  input  ccpt_pkg::entry_t          new_entry,
  input  ccpt_pkg::entry_t          next_entry,
  input  logic [ccpt_pkg::ADDR_W-1:0] cpu_addr,
  input  logic [ccpt_pkg::BYTE_W-1:0] rom_byte,
  output ccpt_pkg::entry_t          entry,
  output logic                      match
);
  import ccpt_pkg::*;

  entry_t entry_r, entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load_new) begin
      entry_nxt = new_entry;
    end else if (ctl.shift) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign match = (entry_r.addr == cpu_addr) && (!entry_r.cen || (entry_r.cmp == rom_byte));

endmodule

FILE: hdl/cheat_code_patch_table.sv
// Top level of the patch-code table: handshake, entry count and the row of slots.
//
//  channel | dir | beat content
//  in_     | in  | tuser opcode; tdata address, rom byte, letters, length, remove index
//  out_    | out | tdata hit, patch byte, status, entry total
//
// One beat per cycle: every item finishes in the cycle it is accepted and its
// result sits in the output register on the next cycle. Lookups compare all
// slots in parallel; removes shift the slots at and above the index down by one,
// each slot taking its upper neighbor. Reset clears the entry count and the
// output valid flag; slot contents need no clearing. A stalled output holds and
// in_tready drops.
module cheat_code_patch_table #(
  parameter int unsigned MAX_CODES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [15:0] cpu_address, [23:16] rom_byte, [87:24] code_chars,
  // [95:88] code_length, [99:96] remove_index, [103:100] zero
  input  logic [ccpt_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] opcode
  input  logic [ccpt_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] hit, [8:1] patch_byte, [10:9] status, [15:11] entry_total
  output logic [ccpt_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import ccpt_pkg::*;

  localparam int unsigned CW = $clog2(MAX_CODES + 1);

  opcode_t     opcode;
  logic [15:0] cpu_address;
  logic [7:0]  rom_byte;
  logic [63:0] code_chars;
  logic [7:0]  code_length;
  logic [3:0]  remove_index;

  assign opcode       = opcode_t'(in_tuser);
  assign cpu_address  = in_tdata[15:0];
  assign rom_byte     = in_tdata[23:16];
  assign code_chars   = in_tdata[87:24];
  assign code_length  = in_tdata[95:88];
  assign remove_index = in_tdata[99:96];

  logic             accept;
  logic [CW-1:0]    count_r, count_nxt;
  logic             out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  entry_t           dec_entry;
  logic             dec_bad;
  logic             full;
  logic             rm_ok;
  logic             add_ok;
  logic [7:0]       rm_wide, count_wide;

  entry_t           entries [MAX_CODES];
  logic [MAX_CODES-1:0] match_raw, match, first;
  cell_ctl_t        ctl [MAX_CODES];

  logic             hit;
  logic [7:0]       pbyte;
  status_t          status;
  logic [6:0]       total_ext;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;

  ccpt_decode u_decode (
    .code_chars (code_chars),
    .code_length(code_length),
    .entry      (dec_entry),
    .bad_code   (dec_bad)
  );

  assign full       = (count_r >= CW'(MAX_CODES));
  assign rm_wide    = 8'(remove_index);
  assign count_wide = 8'(count_r);
  assign rm_ok      = accept && (opcode == OP_REMOVE) && (rm_wide < count_wide);
  assign add_ok     = accept && (opcode == OP_ADD) && !full && !dec_bad;

  for (genvar i = 0; i < MAX_CODES; i++) begin : g_cell
    entry_t nb;
    if (i == MAX_CODES - 1) begin : g_last
      assign nb = entries[i];
    end else begin : g_mid
      assign nb = entries[i+1];
    end

    assign ctl[i].load_new = add_ok && (count_wide == 8'(i));
    assign ctl[i].shift    = rm_ok && (8'(i) >= rm_wide);

    ccpt_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .new_entry (dec_entry),
      .next_entry(nb),
      .cpu_addr  (cpu_address[ADDR_W-1:0]),
      .rom_byte  (rom_byte),
      .entry     (entries[i]),
      .match     (match_raw[i])
    );

    assign match[i] = match_raw[i] && (count_wide > 8'(i)) && cpu_address[15];
  end

  // lowest set bit wins
  assign first = match & (~match + MAX_CODES'(1));

  always_comb begin
    pbyte = '0;
    for (int i = 0; i < MAX_CODES; i++) begin
      pbyte = pbyte | (entries[i].data & {BYTE_W{first[i]}});
    end
  end

  assign hit = (opcode == OP_READ) && (|match);

  always_comb begin
    count_nxt = count_r;
    if (add_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (rm_ok) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    unique case (opcode)
      OP_ADD:    status = full ? ST_FULL : (dec_bad ? ST_BAD_CODE : ST_OK);
      OP_REMOVE: status = (rm_wide < count_wide) ? ST_OK : ST_BAD_INDEX;
      default:   status = ST_OK;
    endcase
  end

  assign total_ext    = 7'(count_nxt);
  assign out_data_nxt = {total_ext[TOTAL_W-1:0], status, (hit ? pbyte : 8'h00), hit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking bench for the patch-code table: directed table, then random phases.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ccpt_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 100000;
  localparam int PHASE_ITEMS = 270;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 250;

  typedef struct {
    opcode_t     op;
    logic [15:0] addr;
    logic [7:0]  rom;
    logic [63:0] chars;
    logic [7:0]  len;
    logic [3:0]  idx;
  } patch_item_t;

  typedef struct {
    logic        hit;
    logic [7:0]  pb;
    status_t     st;
    logic [4:0]  total;
  } patch_result_t;

  typedef struct {
    patch_item_t   it;
    bit            typed;
    patch_result_t want;
  } plan_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  cheat_code_patch_table #(.MAX_CODES(TABLE_DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow copy of the patch table
  int          live_count = 0;
  logic [14:0] slot_addr [TABLE_DEPTH];
  logic [7:0]  slot_data [TABLE_DEPTH];
  logic [7:0]  slot_cmp  [TABLE_DEPTH];
  bit          slot_cen  [TABLE_DEPTH];

  string letter_set = "APZLGITYEOXUKSVN";

  patch_result_t awaited[$];
  plan_row_t     plan[$];

  int errors = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit quiet = 1'b0;
  int n_hits = 0, n_added = 0, n_full = 0, n_bad_code = 0, n_bad_idx = 0, n_removed = 0;
  logic [63:0] last_code = '0;
  patch_result_t head;

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    if (errors <= 60)
      $display("mismatch on result %0d: %s got 0x%0h want 0x%0h", results_seen, what, got, want);
  endtask

  // 0..15 for a code letter, bit 4 set otherwise
  function automatic logic [4:0] nibble_of(input logic [7:0] ch);
    logic [4:0] v;
    v = 5'h10;
    for (int i = 0; i < 16; i++)
      if (letter_set[i] == ch) v = i[4:0];
    return v;
  endfunction

  function automatic logic [63:0] letters(input string txt);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < txt.len(); i++) v[8*i +: 8] = txt[i];
    return v;
  endfunction

  function automatic logic [63:0] rand_code();
    logic [63:0] v;
    for (int i = 0; i < 8; i++) v[8*i +: 8] = letter_set[$urandom_range(0, 15)];
    return v;
  endfunction

  // Applies one item to the shadow table and returns the result it should give.
  function automatic patch_result_t table_step(input patch_item_t it);
    patch_result_t r;
    logic [3:0] n [8];
    logic [4:0] v;
    bit bad;
    bit found;
    r.hit = 1'b0;
    r.pb = '0;
    r.st = ST_OK;
    case (it.op)
      OP_READ: begin
        found = 1'b0;
        if (it.addr[15])
          for (int i = 0; i < live_count; i++)
            if (!found && slot_addr[i] == it.addr[14:0] &&
                (!slot_cen[i] || slot_cmp[i] == it.rom)) begin
              found = 1'b1;
              r.hit = 1'b1;
              r.pb = slot_data[i];
            end
        if (found) n_hits++;
      end
      OP_ADD: begin
        if (live_count >= TABLE_DEPTH) begin
          r.st = ST_FULL;
        end else if (it.len != LEN_SHORT && it.len != LEN_LONG) begin
          r.st = ST_BAD_CODE;
        end else begin
          bad = 1'b0;
          for (int i = 0; i < 8; i++) n[i] = 4'h0;
          for (int i = 0; i < it.len; i++) begin
            v = nibble_of(it.chars[8*i +: 8]);
            if (v[4]) bad = 1'b1;
            n[i] = v[3:0];
          end
          if (bad) begin
            r.st = ST_BAD_CODE;
          end else begin
            slot_addr[live_count] = {n[3][2:0], n[4][3], n[5][2:0], n[1][3], n[2][2:0],
                                     n[3][3], n[4][2:0]};
            slot_data[live_count] = {n[0][3], n[1][2:0],
                                     (it.len == LEN_SHORT) ? n[5][3] : n[7][3], n[0][2:0]};
            slot_cmp[live_count]  = (it.len == LEN_SHORT) ? 8'h00 :
                                    {n[6][3], n[7][2:0], n[5][3], n[6][2:0]};
            slot_cen[live_count]  = (it.len == LEN_LONG);
            live_count++;
          end
        end
        case (r.st)
          ST_OK:       n_added++;
          ST_FULL:     n_full++;
          default:     n_bad_code++;
        endcase
      end
      OP_REMOVE: begin
        if (it.idx >= live_count) begin
          r.st = ST_BAD_INDEX;
          n_bad_idx++;
        end else begin
          for (int i = it.idx; i < live_count - 1; i++) begin
            slot_addr[i] = slot_addr[i+1];
            slot_data[i] = slot_data[i+1];
            slot_cmp[i]  = slot_cmp[i+1];
            slot_cen[i]  = slot_cen[i+1];
          end
          live_count--;
          n_removed++;
        end
      end
      default: ;
    endcase
    r.total = live_count[4:0];
    return r;
  endfunction

  function automatic plan_row_t row(input opcode_t op, input logic [15:0] addr,
                                    input logic [7:0] rom, input logic [63:0] chars,
                                    input logic [7:0] len, input logic [3:0] idx,
                                    input bit typed, input logic hit, input logic [7:0] pb,
                                    input status_t st, input logic [4:0] total);
    plan_row_t p;
    p.it.op = op;
    p.it.addr = addr;
    p.it.rom = rom;
    p.it.chars = chars;
    p.it.len = len;
    p.it.idx = idx;
    p.typed = typed;
    p.want.hit = hit;
    p.want.pb = pb;
    p.want.st = st;
    p.want.total = total;
    return p;
  endfunction

  // Random item; weights are percentages for read, add and remove, the rest unused opcode.
  function automatic patch_item_t rand_item(input int w_read, input int w_add, input int w_rem);
    patch_item_t it;
    int r;
    int k;
    it.addr = 16'($urandom);
    it.rom = 8'($urandom);
    it.chars = {$urandom, $urandom};
    it.len = 8'($urandom);
    it.idx = 4'($urandom);
    r = $urandom_range(0, 99);
    if (r < w_read) begin
      it.op = OP_READ;
      if (live_count > 0 && $urandom_range(0, 9) < 6) begin
        k = $urandom_range(0, live_count - 1);
        it.addr = {1'b1, slot_addr[k]};
        if ($urandom_range(0, 1)) it.rom = slot_cmp[k];
      end
    end else if (r < w_read + w_add) begin
      it.op = OP_ADD;
      r = $urandom_range(0, 99);
      if (r < 95) begin
        it.chars = rand_code();
        // same address letters as the last code: duplicates test first-match order
        if ($urandom_range(0, 3) == 0) it.chars[47:8] = last_code[47:8];
        if ($urandom_range(0, 1)) it.chars[63:48] = 16'($urandom);
        it.len = $urandom_range(0, 1) ? LEN_LONG : LEN_SHORT;
        last_code = it.chars;
        if (r >= 85) begin
          k = $urandom_range(0, it.len - 1);
          it.chars[8*k +: 8] = 8'($urandom_range(0, 1) ? $urandom :
                                    (32'h61 + $urandom_range(0, 25)));
        end else if (r >= 75) begin
          it.len = 8'($urandom);
        end
      end
    end else if (r < w_read + w_add + w_rem) begin
      it.op = OP_REMOVE;
      if (live_count > 0 && $urandom_range(0, 9) < 8) begin
        it.idx = 4'($urandom_range(0, live_count - 1));
      end
    end else begin
      it.op = OP_NONE;
    end
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic offer(input patch_item_t it, input bit typed, input patch_result_t want);
    int gap;
    patch_result_t pred;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.op;
    in_tdata <= {4'h0, it.idx, it.len, it.chars, it.rom, it.addr};
    do @(posedge clk); while (!in_tready);
    pred = table_step(it);
    awaited.push_back(typed ? want : pred);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (awaited.size() != 0) @(negedge clk);
  endtask

  // receiver: short random stalls per beat plus one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (awaited.size() == 0) begin
        report("beat with nothing expected", out_tdata, 0);
      end else begin
        head = awaited.pop_front();
        if (out_tdata[0] !== head.hit) report("hit", out_tdata[0], head.hit);
        if (out_tdata[8:1] !== head.pb) report("patch_byte", out_tdata[8:1], head.pb);
        if (out_tdata[10:9] !== head.st) report("status", out_tdata[10:9], head.st);
        if (out_tdata[15:11] !== head.total) report("entry_total", out_tdata[15:11], head.total);
      end
      stall_left = quiet ? 0 : $urandom_range(0, 5);
      if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, awaited.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    patch_result_t none;
    none.hit = 1'b0;
    none.pb = '0;
    none.st = ST_OK;
    none.total = '0;

    // op, address, rom byte, letters, length, index, typed, hit, byte, status, total
    plan.push_back(row(OP_READ,   16'hFFFF, 8'h00, '0, 8'd0, 4'd0, 1, 0, 8'h00, ST_OK, 0));
    plan.push_back(row(OP_REMOVE, 16'h0000, 8'h00, '0, 8'd0, 4'd0, 1, 0, 8'h00, ST_BAD_INDEX, 0));
    plan.push_back(row(OP_REMOVE, 16'h0000, 8'h00, '0, 8'd0, 4'd15, 1, 0, 8'h00, ST_BAD_INDEX, 0));
    plan.push_back(row(OP_ADD, 16'h0000, 8'h00, letters("GOSSIP"), LEN_SHORT, 4'd0,
                       0, 0, 8'h00, ST_OK, 0));
    plan.push_back(row(OP_ADD, 16'h0000, 8'h00, letters("ZEXPYGLA"), LEN_LONG, 4'd0,
                       0, 0, 8'h00, ST_OK, 0));
    plan.push_back(row(OP_ADD, 16'h0000, 8'h00, letters("ZEXPYGL"), 8'd7, 4'd0,
                       1, 0, 8'h00, ST_BAD_CODE, 2));
    plan.push_back(row(OP_ADD, 16'h0000, 8'h00, letters("ZEXPYGLA"), 8'd0, 4'd0,
                       1, 0, 8'h00, ST_BAD_CODE, 2));
    plan.push_back(row(OP_ADD, 16'h0000, 8'h00, letters("ZEXPYGLA"), 8'd255, 4'd0,
                       1, 0, 8'h00, ST_BAD_CODE, 2));
    // lower-case letter is outside the alphabet
    plan.push_back(row(OP_ADD, 16'h0000, 8'h00, letters("GOSsIP"), LEN_SHORT, 4'd0,
                       1, 0, 8'h00, ST_BAD_CODE, 2));
    plan.push_back(row(OP_ADD, 16'h0000, 8'h00, letters("GOSSIQ"), LEN_SHORT, 4'd0,
                       1, 0, 8'h00, ST_BAD_CODE, 2));
    plan.push_back(row(OP_ADD, 16'h0000, 8'h00, letters("ZEXPYGL!"), LEN_LONG, 4'd0,
                       1, 0, 8'h00, ST_BAD_CODE, 2));
    // trailing bytes past the length are don't-care
    plan.push_back(row(OP_ADD, 16'h0000, 8'h00, letters("NNNNNN") | 64'hFF80_0000_0000_0000,
                       LEN_SHORT, 4'd0, 0, 0, 8'h00, ST_OK, 0));
    plan.push_back(row(OP_ADD, 16'h0000, 8'h00, letters("AAAAAAAA"), LEN_LONG, 4'd0,
                       0, 0, 8'h00, ST_OK, 0));
    // low half of the address space never matches, even with the low bits equal
    plan.push_back(row(OP_READ,   16'h7FFF, 8'hFF, '1, 8'hFF, 4'hF, 1, 0, 8'h00, ST_OK, 4));
    plan.push_back(row(OP_READ,   16'hFFFF, 8'h00, '0, 8'd0, 4'd0, 0, 0, 8'h00, ST_OK, 0));
    plan.push_back(row(OP_READ,   16'h8000, 8'h00, '0, 8'd0, 4'd0, 0, 0, 8'h00, ST_OK, 0));
    plan.push_back(row(OP_READ,   16'h8000, 8'h01, '0, 8'd0, 4'd0, 0, 0, 8'h00, ST_OK, 0));
    plan.push_back(row(OP_NONE,   16'hFFFF, 8'hFF, '1, LEN_SHORT, 4'd0, 1, 0, 8'h00, ST_OK, 4));
    plan.push_back(row(OP_REMOVE, 16'h0000, 8'h00, '0, 8'd0, 4'd4, 1, 0, 8'h00, ST_BAD_INDEX, 4));
    plan.push_back(row(OP_REMOVE, 16'h0000, 8'h00, '0, 8'd0, 4'd0, 0, 0, 8'h00, ST_OK, 0));
    plan.push_back(row(OP_REMOVE, 16'h0000, 8'h00, '0, 8'd0, 4'd2, 0, 0, 8'h00, ST_OK, 0));
    plan.push_back(row(OP_READ,   16'hFFFF, 8'h00, '0, 8'd0, 4'd0, 0, 0, 8'h00, ST_OK, 0));

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) offer(plan[i].it, plan[i].typed, plan[i].want);
    drain();

    // balanced, add-heavy (fills to full), remove-heavy, then balanced back to back
    for (int ph = 0; ph < 4; ph++) begin
      quiet = (ph == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case (ph)
          1:       offer(rand_item(30, 60, 5), 1'b0, none);
          2:       offer(rand_item(40, 15, 40), 1'b0, none);
          default: offer(rand_item(45, 30, 20), 1'b0, none);
        endcase
      end
      drain();
    end

    repeat (8) @(negedge clk);
    $display("ran %0d beats: %0d lookup hits, %0d codes added, %0d removed", beats_sent,
             n_hits, n_added, n_removed);
    $display("rejections: %0d full table, %0d bad code, %0d bad index", n_full, n_bad_code,
             n_bad_idx);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
